>>> rtl/kocnt_pkg.sv
// kocnt_pkg: shared widths and register addresses of the keyword occurrence counter
`timescale 1ns / 1ps
package kocnt_pkg;

  // keyword storage is fixed at two 64-bit registers, sixteen bytes
  localparam int unsigned KEY_BITS    = 128;
  localparam int unsigned KEY_IDX_W   = 4;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OUT_CNT_W   = 16;

  // apb port
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned REG_SEL_W   = 2;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_NONE     = 2'd3
  } reg_sel_e;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd1;

endpackage

>>> rtl/kocnt_if.sv
// kocnt_if: valid/ready channel interfaces for text words and result words
`timescale 1ns / 1ps
interface kocnt_text_if;
  logic                            valid;
  logic                            ready;
  logic [kocnt_pkg::BYTE_W-1:0]    text_byte;
  logic                            end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kocnt_result_if;
  logic                            valid;
  logic                            ready;
  logic                            match_ends_here;
  logic [kocnt_pkg::OUT_CNT_W-1:0] occurrence_count;
  logic                            final_result;

  modport source (output valid, output match_ends_here, output occurrence_count,
                  output final_result, input ready);
  modport sink   (input valid, input match_ends_here, input occurrence_count,
                  input final_result, output ready);
endinterface

>>> rtl/kocnt_cell.sv
// kocnt_cell: one window stage holding a past byte and comparing it to its keyword byte
`timescale 1ns / 1ps
module kocnt_cell #(
  parameter int unsigned POS = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic                                 clear_i,
  input  logic [kocnt_pkg::BYTE_W-1:0]         byte_i,
  output logic [kocnt_pkg::BYTE_W-1:0]         byte_o,
  input  logic [kocnt_pkg::KEY_BITS-1:0]       key_i,
  input  logic [kocnt_pkg::KEY_LEN_W-1:0]      key_len_i,
  input  logic                                 match_i,
  output logic                                 match_o
);

  localparam logic [kocnt_pkg::KEY_LEN_W-1:0] PosL = kocnt_pkg::KEY_LEN_W'(POS);

  logic [kocnt_pkg::BYTE_W-1:0]    byte_q;
  logic [kocnt_pkg::KEY_LEN_W-1:0] key_pos;
  logic [kocnt_pkg::KEY_IDX_W-1:0] key_idx;
  logic                            in_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= clear_i ? '0 : byte_i;
    end
  end

  // this cell holds the byte POS places back, matched against key byte len-1-POS
  assign in_use  = (PosL < key_len_i);
  assign key_pos = key_len_i - 5'd1 - PosL;
  assign key_idx = key_pos[kocnt_pkg::KEY_IDX_W-1:0];

  assign match_o = match_i &
                   (!in_use || (byte_q == key_i[key_idx*kocnt_pkg::BYTE_W +: kocnt_pkg::BYTE_W]));
  assign byte_o  = byte_q;

endmodule

>>> rtl/keyword_occurrence_counter_core.sv
// keyword_occurrence_counter_core: streaming keyword occurrence counter, top level
`timescale 1ns / 1ps
// Counts occurrences, overlapping ones included, of a keyword of 1 to
// MAX_KEY_LEN bytes in a text that arrives one byte per word on text_i. Each
// accepted byte yields exactly one word on result_o: whether an occurrence ends
// at that byte, the count so far in the sentence (saturating at
// 2^COUNT_BITS-1, low 16 bits shown) and a flag set on the sentence's last byte.
// The last byte also clears the window and the count. The block takes one byte
// every cycle unless a skid word waits: past bytes sit in a row of MAX_KEY_LEN-1
// cells that shift once per byte, and the whole window is compared against the
// keyword in the same cycle through an AND chain along the row. A two-word
// output buffer lets a new byte enter while a result still waits. Write keyword
// and length over the APB port (key_bytes_low at 0x0, key_bytes_high at 0x8,
// key_length at 0x10) only while the block is idle; the block does not enforce
// it. A length of zero never matches, one above MAX_KEY_LEN acts as MAX_KEY_LEN.
module keyword_occurrence_counter_core #(
  parameter int unsigned MAX_KEY_LEN = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  kocnt_text_if.sink                            text_i,
  kocnt_result_if.source                        result_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [kocnt_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [kocnt_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [kocnt_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int unsigned WinDepth = MAX_KEY_LEN - 1;
  localparam int unsigned SeenW    = $clog2(MAX_KEY_LEN);
  localparam logic [kocnt_pkg::KEY_LEN_W-1:0] MaxLen = kocnt_pkg::KEY_LEN_W'(MAX_KEY_LEN);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(WinDepth);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]                       key_low_q;
  logic [63:0]                       key_high_q;
  logic [kocnt_pkg::KEY_LEN_W-1:0]   key_len_q;
  kocnt_pkg::reg_sel_e               reg_sel;
  logic                              cfg_wr;

  assign reg_sel = kocnt_pkg::reg_sel_e'(paddr[kocnt_pkg::APB_ADDR_W-1 -: kocnt_pkg::REG_SEL_W]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= kocnt_pkg::KEY_LEN_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        kocnt_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
        kocnt_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
        kocnt_pkg::REG_KEY_LEN:  key_len_q  <= pwdata[kocnt_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kocnt_pkg::REG_KEY_LOW:  prdata = key_low_q;
      kocnt_pkg::REG_KEY_HIGH: prdata = key_high_q;
      kocnt_pkg::REG_KEY_LEN:  prdata = 64'(key_len_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // window compare
  // ---------------------------------------------------------------------------
  logic [kocnt_pkg::KEY_BITS-1:0]  key;
  logic [kocnt_pkg::KEY_LEN_W-1:0] len_eff;
  logic [kocnt_pkg::KEY_LEN_W-1:0] last_pos;
  logic                            push;
  logic                            last_byte;
  logic                            hit;
  logic                            head_match;

  logic [SeenW-1:0]                bytes_seen_q, bytes_seen_d;
  logic [COUNT_BITS-1:0]           count_q, count_d;

  logic [kocnt_pkg::BYTE_W-1:0]    win_byte [WinDepth+1];
  logic [WinDepth:0]               win_match;

  assign key       = {key_high_q, key_low_q};
  assign len_eff   = (key_len_q > MaxLen) ? MaxLen : key_len_q;
  assign last_pos  = len_eff - 5'd1;
  assign push      = text_i.valid & text_i.ready;
  assign last_byte = text_i.end_of_text;

  // newest byte against the keyword's last byte; it also carries the fill check
  assign head_match = (len_eff != '0) &&
                      (kocnt_pkg::KEY_LEN_W'(bytes_seen_q) + 5'd1 >= len_eff) &&
                      (text_i.text_byte ==
                       key[last_pos[kocnt_pkg::KEY_IDX_W-1:0]*kocnt_pkg::BYTE_W +:
                           kocnt_pkg::BYTE_W]);

  assign win_byte[0]  = text_i.text_byte;
  assign win_match[0] = head_match;

  for (genvar g = 1; g <= WinDepth; g++) begin : g_cell
    kocnt_cell #(
      .POS (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (push),
      .clear_i   (last_byte),
      .byte_i    (win_byte[g-1]),
      .byte_o    (win_byte[g]),
      .key_i     (key),
      .key_len_i (len_eff),
      .match_i   (win_match[g-1]),
      .match_o   (win_match[g])
    );
  end

  assign hit = win_match[WinDepth];

  // running count saturates; fill count stops at the window depth
  always_comb begin
    count_d      = count_q;
    bytes_seen_d = bytes_seen_q;
    if (hit && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
    if (bytes_seen_q != SeenMax) begin
      bytes_seen_d = bytes_seen_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      count_q      <= '0;
    end else if (push) begin
      if (last_byte) begin
        bytes_seen_q <= '0;
        count_q      <= '0;
      end else begin
        bytes_seen_q <= bytes_seen_d;
        count_q      <= count_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output buffer: main word plus one skid word
  // ---------------------------------------------------------------------------
  logic [31:0]                      count_ext;
  logic                             pop;
  logic                             m_valid_q, s_valid_q;
  logic                             m_hit_q, s_hit_q;
  logic [kocnt_pkg::OUT_CNT_W-1:0]  m_cnt_q, s_cnt_q, new_cnt;
  logic                             m_last_q, s_last_q;

  assign count_ext    = 32'(count_d);
  assign new_cnt      = count_ext[kocnt_pkg::OUT_CNT_W-1:0];
  assign pop          = result_o.valid & result_o.ready;
  assign text_i.ready = !s_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (s_valid_q) begin
        if (pop) begin
          m_valid_q <= 1'b1;
          s_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (m_valid_q && !pop) begin
          s_valid_q <= 1'b1;
        end
        m_valid_q <= 1'b1;
      end else if (pop) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q) begin
      if (pop) begin
        m_hit_q  <= s_hit_q;
        m_cnt_q  <= s_cnt_q;
        m_last_q <= s_last_q;
      end
    end else if (push) begin
      if (m_valid_q && !pop) begin
        s_hit_q  <= hit;
        s_cnt_q  <= new_cnt;
        s_last_q <= last_byte;
      end else begin
        m_hit_q  <= hit;
        m_cnt_q  <= new_cnt;
        m_last_q <= last_byte;
      end
    end
  end

  assign result_o.valid            = m_valid_q;
  assign result_o.match_ends_here  = m_hit_q;
  assign result_o.occurrence_count = m_cnt_q;
  assign result_o.final_result     = m_last_q;

`ifndef SYNTHESIS
  // skid word only ever sits behind a main word
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_valid_q |-> m_valid_q)
    else $error("skid word held without main word");

  // last byte of a sentence leaves fill count and running count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last_byte |=> (bytes_seen_q == '0) && (count_q == '0))
    else $error("sentence state not cleared after last byte");

  // inside a sentence the count never goes down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !last_byte |=> count_q >= $past(count_q))
    else $error("running count decreased inside a sentence");
`endif

endmodule

>>> tb/tb_keyword_occurrence_counter_core.sv
// tb_keyword_occurrence_counter_core: self-checking bench for the keyword occurrence counter
`timescale 1ns / 1ps
module tb_keyword_occurrence_counter_core;

  // window holds the previous MAX_KEY_LEN-1 bytes of the sentence
  localparam int unsigned KEY_MAX      = 16;
  localparam int unsigned WINDOW_DEPTH = KEY_MAX - 1;
  localparam logic [kocnt_pkg::OUT_CNT_W-1:0] COUNT_CAP = 16'hFFFF;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned PHASE_ITEMS  = 200;
  // one long sentence with a match on every byte
  localparam int unsigned LONG_RUN     = 300;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned MAX_REPORTS  = 30;

  // one result word as the sink sees it
  typedef struct packed {
    logic                            hit;
    logic [kocnt_pkg::OUT_CNT_W-1:0] count;
    logic                            last;
  } tally_t;

  // an expected word typed into the directed table overrides the predictor
  typedef struct packed {
    logic   typed;
    tally_t tally;
  } typed_tally_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_e;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_MOSTLY,
    SINK_COIN,
    SINK_ALTERNATE
  } sink_mode_e;

  typedef struct packed {
    row_kind_e                        kind;
    kocnt_pkg::reg_sel_e              sel;
    logic [kocnt_pkg::APB_DATA_W-1:0] value;
    logic [kocnt_pkg::BYTE_W-1:0]     text;
    logic                             eot;
    logic                             typed;
    tally_t                           want;
  } dir_row_t;

  localparam typed_tally_t UNTYPED = '0;
  localparam int unsigned DIR_ROWS = 24;

  // directed rows: typed words only where the answer is obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset keyword is one zero byte
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h00, 1'b0, 1'b1, {1'b1, 16'd1, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b0, 16'd1, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h00, 1'b1, 1'b1, {1'b1, 16'd2, 1'b1}},
    // count and window cleared by the last byte
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b1, 1'b1, {1'b0, 16'd0, 1'b1}},
    '{ROW_CFG, kocnt_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, kocnt_pkg::REG_KEY_LEN, 64'd3, 8'h00, 1'b0, 1'b0, '0},
    // sentence shorter than the keyword
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b0, 16'd0, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b1, 1'b1, {1'b0, 16'd0, 1'b1}},
    // overlapping occurrences both count
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b0, 16'd0, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b0, 16'd0, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b1, 16'd1, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b1, 1'b1, {1'b1, 16'd2, 1'b1}},
    // empty keyword never matches
    '{ROW_CFG, kocnt_pkg::REG_KEY_LEN, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b1, {1'b0, 16'd0, 1'b0}},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h00, 1'b1, 1'b1, {1'b0, 16'd0, 1'b1}},
    // oversized length acts as the full sixteen bytes
    '{ROW_CFG, kocnt_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, kocnt_pkg::REG_KEY_LEN, 64'd31, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h7E, 1'b1, 1'b0, '0},
    '{ROW_CFG, kocnt_pkg::REG_KEY_LOW, 64'h8040_2010_0804_0201, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, kocnt_pkg::REG_KEY_LEN, 64'd2, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h01, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h02, 1'b0, 1'b0, '0},
    '{ROW_TEXT, kocnt_pkg::REG_NONE, 64'h0, 8'h80, 1'b1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [kocnt_pkg::APB_ADDR_W-1:0] paddr;
  logic [kocnt_pkg::APB_DATA_W-1:0] pwdata;
  logic [kocnt_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  kocnt_text_if   text_if ();
  kocnt_result_if result_if ();

  keyword_occurrence_counter_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor copy of the keyword registers
  logic [kocnt_pkg::APB_DATA_W-1:0] key_lo_cfg  = '0;
  logic [kocnt_pkg::APB_DATA_W-1:0] key_hi_cfg  = '0;
  logic [kocnt_pkg::KEY_LEN_W-1:0]  key_len_cfg = kocnt_pkg::KEY_LEN_RESET;

  // predictor copy of the sentence state
  logic [kocnt_pkg::BYTE_W-1:0]    recent_win [WINDOW_DEPTH];
  int unsigned                     seen_cnt   = 0;
  logic [kocnt_pkg::OUT_CNT_W-1:0] tally_cnt  = '0;

  typed_tally_t typed_tally_q [$];
  tally_t       expected_tally_q [$];

  int unsigned err_cnt       = 0;
  int unsigned burst_left    = 0;
  bit          no_gaps       = 1'b0;
  int unsigned hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (recent_win[i]) recent_win[i] = '0;
  end

  function automatic logic [kocnt_pkg::BYTE_W-1:0] key_at(input int unsigned pos);
    logic [2*kocnt_pkg::APB_DATA_W-1:0] key_image;
    key_image = {key_hi_cfg, key_lo_cfg};
    return key_image[8*(pos % KEY_MAX) +: 8];
  endfunction

  // effective keyword length after clamping oversized values
  function automatic int unsigned key_span();
    return (key_len_cfg > KEY_MAX) ? KEY_MAX : int'(key_len_cfg);
  endfunction

  // one step of the counter: compare the window plus this byte against the keyword
  function automatic tally_t predict_tally(input logic [kocnt_pkg::BYTE_W-1:0] b,
                                           input logic last);
    tally_t      res;
    int unsigned len;
    logic        hit;
    len = key_span();
    hit = 1'b0;
    // a match needs len-1 earlier bytes of this sentence in the window
    if (len != 0 && seen_cnt + 1 >= len) begin
      hit = (key_at(len - 1) == b);
      for (int unsigned k = 1; k < len; k++) begin
        if (recent_win[k-1] != key_at(len - 1 - k)) hit = 1'b0;
      end
    end
    // count holds at its ceiling
    if (hit && tally_cnt != COUNT_CAP) tally_cnt++;
    res.hit   = hit;
    res.count = tally_cnt;
    res.last  = last;
    if (last) begin
      foreach (recent_win[i]) recent_win[i] = '0;
      seen_cnt  = 0;
      tally_cnt = '0;
    end else begin
      for (int unsigned i = WINDOW_DEPTH - 1; i > 0; i--) recent_win[i] = recent_win[i-1];
      recent_win[0] = b;
      if (seen_cnt < WINDOW_DEPTH) seen_cnt++;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what,
                               input logic [kocnt_pkg::APB_DATA_W-1:0] want,
                               input logic [kocnt_pkg::APB_DATA_W-1:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // monitor: predict on every accepted text word, then check every accepted result word
  always @(posedge clk_i) begin
    typed_tally_t row_chk;
    tally_t       guess;
    tally_t       got;
    tally_t       want;
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) begin
        guess   = predict_tally(text_if.text_byte, text_if.end_of_text);
        row_chk = (typed_tally_q.size() != 0) ? typed_tally_q.pop_front() : UNTYPED;
        expected_tally_q.push_back(row_chk.typed ? row_chk.tally : guess);
      end
      if (result_if.valid && result_if.ready) begin
        got.hit   = result_if.match_ends_here;
        got.count = result_if.occurrence_count;
        got.last  = result_if.final_result;
        if (expected_tally_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: result word with none expected, expected nothing, got 0x%0h",
                     $time, got);
          end
        end else begin
          want = expected_tally_q.pop_front();
          if (got.hit !== want.hit) begin
            flag_mismatch("match_ends_here", kocnt_pkg::APB_DATA_W'(want.hit),
                          kocnt_pkg::APB_DATA_W'(got.hit));
          end
          if (got.count !== want.count) begin
            flag_mismatch("occurrence_count", kocnt_pkg::APB_DATA_W'(want.count),
                          kocnt_pkg::APB_DATA_W'(got.count));
          end
          if (got.last !== want.last) begin
            flag_mismatch("final_result", kocnt_pkg::APB_DATA_W'(want.last),
                          kocnt_pkg::APB_DATA_W'(got.last));
          end
        end
      end
    end
  end

  // result sink: ready follows a mode that is picked anew at random after a random span,
  // and a requested hold keeps ready low for a long stretch
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned span_left;
    int unsigned hold_left;
    int unsigned holds_done;
    result_if.ready = 1'b0;
    mode       = SINK_OPEN;
    span_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (span_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        span_left = $urandom_range(8, 64);
      end
      span_left--;
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   result_if.ready <= 1'b1;
          SINK_MOSTLY: result_if.ready <= ($urandom_range(0, 3) != 0);
          SINK_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
          default:     result_if.ready <= span_left[0];
        endcase
      end
    end
  end

  // offer one text word; bursts of random length with random gaps in front of them
  task automatic push_text(input logic [kocnt_pkg::BYTE_W-1:0] b, input logic last,
                           input typed_tally_t chk);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_tally_q.push_back(chk);
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= last;
    do @(posedge clk_i); while (!text_if.ready);
    burst_left--;
  endtask

  task automatic idle_text();
    @(negedge clk_i);
    text_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // register write once every result is back, then read it back
  task automatic cfg_write(input kocnt_pkg::reg_sel_e sel,
                           input logic [kocnt_pkg::APB_DATA_W-1:0] value);
    logic [kocnt_pkg::APB_DATA_W-1:0] held;
    idle_text();
    while (expected_tally_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    held = (sel == kocnt_pkg::REG_KEY_LEN) ?
           kocnt_pkg::APB_DATA_W'(value[kocnt_pkg::KEY_LEN_W-1:0]) : value;
    // setup phase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    // access phase
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      kocnt_pkg::REG_KEY_LOW:  key_lo_cfg = value;
      kocnt_pkg::REG_KEY_HIGH: key_hi_cfg = value;
      kocnt_pkg::REG_KEY_LEN:  key_len_cfg = value[kocnt_pkg::KEY_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== held) flag_mismatch("register read back", held, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // keyword and length for one random phase; first phases pin the length extremes
  task automatic pick_keyword(input int unsigned phase);
    logic [2*kocnt_pkg::APB_DATA_W-1:0] key_image;
    int unsigned                        flavor;
    int unsigned                        len;
    flavor = $urandom_range(0, 9);
    for (int unsigned k = 0; k < KEY_MAX; k++) begin
      case (flavor)
        0:       key_image[8*k +: 8] = 8'h00;
        1:       key_image[8*k +: 8] = 8'hFF;
        // two-letter alphabet makes self-overlapping keywords common
        2, 3, 4: key_image[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
        default: key_image[8*k +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    if (phase == 0) len = KEY_MAX;
    else if (phase == 1) len = $urandom_range(KEY_MAX + 1, 31);
    else begin
      case ($urandom_range(0, 15))
        0:       len = 0;
        1:       len = KEY_MAX;
        2:       len = $urandom_range(KEY_MAX + 1, 31);
        3, 4:    len = $urandom_range(5, KEY_MAX - 1);
        default: len = $urandom_range(1, 4);
      endcase
    end
    cfg_write(kocnt_pkg::REG_KEY_LOW, key_image[kocnt_pkg::APB_DATA_W-1:0]);
    cfg_write(kocnt_pkg::REG_KEY_HIGH,
              key_image[2*kocnt_pkg::APB_DATA_W-1:kocnt_pkg::APB_DATA_W]);
    cfg_write(kocnt_pkg::REG_KEY_LEN, kocnt_pkg::APB_DATA_W'(len));
  endtask

  initial begin : stimulus
    logic [kocnt_pkg::BYTE_W-1:0] sentence_q [$];
    typed_tally_t                 chk;
    int unsigned                  random_sent;
    int unsigned                  phase;
    int unsigned                  phase_items;
    int unsigned                  sent_len;
    int unsigned                  span;

    rst_ni              = 1'b0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    random_sent         = 0;
    phase               = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].sel, dir_rows[i].value);
      end else begin
        chk.typed = dir_rows[i].typed;
        chk.tally = dir_rows[i].want;
        push_text(dir_rows[i].text, dir_rows[i].eot, chk);
      end
    end

    // long sentence: single-byte keyword matching on every byte, back to back
    cfg_write(kocnt_pkg::REG_KEY_LOW, 64'h5A);
    cfg_write(kocnt_pkg::REG_KEY_LEN, 64'd1);
    no_gaps = 1'b1;
    for (int unsigned n = 0; n < LONG_RUN; n++) begin
      push_text(8'h5A, n == LONG_RUN - 1, UNTYPED);
    end
    no_gaps = 1'b0;

    // random phases: mostly sentences built from keyword copies and keyword
    // bytes, with random noise bytes mixed in
    while (random_sent < RANDOM_ITEMS) begin
      pick_keyword(phase);
      span = (key_span() == 0) ? 1 : key_span();
      // long sink hold while the source keeps offering words back to back
      if (phase == 2) begin
        hold_requests++;
        no_gaps = 1'b1;
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_sent < RANDOM_ITEMS) begin
        sentence_q = {};
        sent_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120)
                                                 : $urandom_range(1, 30);
        while (sentence_q.size() < sent_len) begin
          if ($urandom_range(0, 2) == 0) begin
            for (int unsigned k = 0; k < span; k++) sentence_q.push_back(key_at(k));
          end else if ($urandom_range(0, 2) != 0) begin
            sentence_q.push_back(key_at($urandom_range(0, span - 1)));
          end else begin
            sentence_q.push_back(kocnt_pkg::BYTE_W'($urandom_range(0, 255)));
          end
        end
        foreach (sentence_q[i]) begin
          push_text(sentence_q[i], i == sentence_q.size() - 1, UNTYPED);
        end
        phase_items += sentence_q.size();
        random_sent += sentence_q.size();
      end
      no_gaps = 1'b0;
      phase++;
    end

    // drain and let the pipeline settle
    idle_text();
    while (expected_tally_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[keyword_occurrence_counter_core] OK");
    end else begin
      $display("[keyword_occurrence_counter_core] ERROR");
    end
    $finish;
  end

  // run guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[keyword_occurrence_counter_core] ERROR");
    $finish;
  end

endmodule
